### rtl/hcbd_pkg.sv
`default_nettype none
package hcbd_pkg;

  // Item kind carried in in_tuser
  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  // Fixed field widths
  localparam int BYTE_W     = 8;
  localparam int LEN_FIELD_W = 31;
  localparam int STATUS_W   = 3;
  localparam int TDATA_W    = 40;

  // Characters the decoder reacts to
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_X_LO  = 8'h78;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_DATA    = 3'd1,
    PH_CRLF    = 3'd2,
    PH_TRAILER = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    PS_BLANK      = 2'd0,
    PS_AFTER_SIGN = 2'd1,
    PS_DIGITS     = 2'd2,
    PS_STOP       = 2'd3
  } parse_step_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_CONSUMED  = 3'd0,
    ST_BODY_BYTE = 3'd1,
    ST_COMPLETE  = 3'd2,
    ST_MALFORMED = 3'd3,
    ST_AFTER_END = 3'd4,
    ST_STARTED   = 3'd5
  } status_t;

  typedef struct packed {
    parse_step_t step;
    logic        negative;
    logic        digit_seen;
    logic        lone_zero;
  } size_ctl_t;

  localparam size_ctl_t SIZE_CTL_CLEAR = '{
    step: PS_BLANK, negative: 1'b0, digit_seen: 1'b0, lone_zero: 1'b0
  };

endpackage
`default_nettype wire

### rtl/hcbd_size_parse.sv
`default_nettype none
module hcbd_size_parse #(
  parameter int LENGTH_BITS = 31
) (
  input  wire logic [7:0]             c,
  input  wire hcbd_pkg::size_ctl_t    ctl_in,
  input  wire logic [LENGTH_BITS-1:0] accum_in,
  output hcbd_pkg::size_ctl_t         ctl_out,
  output logic [LENGTH_BITS-1:0]      accum_out
);
  import hcbd_pkg::*;

  logic       is_hex;
  logic [3:0] hex_val;
  logic       is_blank;
  logic       handled;

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      hex_val = c[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  assign is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);

  always_comb begin
    ctl_out   = ctl_in;
    accum_out = accum_in;
    handled   = 1'b0;
    if (ctl_in.step == PS_STOP) begin
      handled = 1'b1;
    end else if (c == CH_SEMI || c == CH_NUL) begin
      ctl_out.step = PS_STOP;
      handled      = 1'b1;
    end else if (ctl_in.step == PS_BLANK) begin
      if (is_blank) begin
        handled = 1'b1;
      end else if (c == CH_PLUS) begin
        ctl_out.step = PS_AFTER_SIGN;
        handled      = 1'b1;
      end else if (c == CH_MINUS) begin
        ctl_out.negative = 1'b1;
        ctl_out.step     = PS_AFTER_SIGN;
        handled          = 1'b1;
      end
    end else if (ctl_in.step == PS_DIGITS && ctl_in.lone_zero &&
                 (c == CH_X_LO || c == CH_X_UP)) begin
      // a single leading 0 followed by x is a hex prefix
      ctl_out.lone_zero = 1'b0;
      ctl_out.step      = PS_AFTER_SIGN;
      handled           = 1'b1;
    end

    if (!handled) begin
      if (is_hex) begin
        ctl_out.lone_zero  = !ctl_in.digit_seen && (hex_val == 4'd0);
        ctl_out.digit_seen = 1'b1;
        ctl_out.step       = PS_DIGITS;
        // saturate once the top nibble is in use
        if (accum_in[LENGTH_BITS-1 -: 4] != 4'd0) begin
          accum_out = {LENGTH_BITS{1'b1}};
        end else begin
          accum_out = {accum_in[LENGTH_BITS-5:0], 4'd0} + LENGTH_BITS'(hex_val);
        end
      end else begin
        ctl_out.step = PS_STOP;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/hcbd_core.sv
`default_nettype none
module hcbd_core #(
  parameter int LENGTH_BITS    = 31,
  parameter int SIZE_LINE_KEEP = 39
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                item_fire,
  input  wire logic                                op,
  input  wire logic [7:0]                          in_byte,
  input  wire logic [hcbd_pkg::LEN_FIELD_W-1:0]    entity_length,
  output logic [7:0]                               out_byte,
  output hcbd_pkg::status_t                        status,
  output logic [hcbd_pkg::LEN_FIELD_W-1:0]         body_remaining
);
  import hcbd_pkg::*;

  localparam int LCW = $clog2(SIZE_LINE_KEEP + 1);
  localparam int CW  = (LENGTH_BITS > LEN_FIELD_W) ? LENGTH_BITS : LEN_FIELD_W;

  phase_t                 phase_r, phase_nxt;
  size_ctl_t              ctl_r, ctl_nxt, ctl_parsed;
  logic [LENGTH_BITS-1:0] accum_r, accum_nxt, accum_parsed;
  logic [LCW-1:0]         line_count_r, line_count_nxt;
  logic                   trailer_nonempty_r, trailer_nonempty_nxt;
  logic [LENGTH_BITS-1:0] chunk_r, chunk_nxt, chunk_dec;
  logic [LENGTH_BITS-1:0] budget_r, budget_nxt, budget_load;
  logic [CW-1:0]          len_wide, budget_wide;
  logic                   size_bad;
  logic                   is_lf;

  hcbd_size_parse #(.LENGTH_BITS(LENGTH_BITS)) u_size_parse (
    .c         (in_byte),
    .ctl_in    (ctl_r),
    .accum_in  (accum_r),
    .ctl_out   (ctl_parsed),
    .accum_out (accum_parsed)
  );

  assign is_lf     = (in_byte == CH_LF);
  assign size_bad  = !ctl_r.digit_seen || (ctl_r.negative && accum_r != '0);
  assign chunk_dec = chunk_r - LENGTH_BITS'(chunk_r != '0);

  // clamp the declared length to the budget register range
  assign len_wide    = CW'(entity_length);
  assign budget_load = (len_wide > CW'({LENGTH_BITS{1'b1}})) ? {LENGTH_BITS{1'b1}}
                                                               : LENGTH_BITS'(len_wide);

  always_comb begin
    phase_nxt = phase_r;
    if (op == OP_START) begin
      phase_nxt = PH_SIZE;
    end else begin
      unique case (phase_r)
        PH_SIZE: begin
          if (is_lf) begin
            if (size_bad)              phase_nxt = PH_DONE;
            else if (accum_r == '0)    phase_nxt = PH_TRAILER;
            else                       phase_nxt = PH_DATA;
          end
        end
        PH_DATA:    if (chunk_dec == '0) phase_nxt = PH_CRLF;
        PH_CRLF:    if (is_lf) phase_nxt = PH_SIZE;
        PH_TRAILER: if (is_lf && !trailer_nonempty_r) phase_nxt = PH_DONE;
        PH_DONE:    phase_nxt = PH_DONE;
        default:    phase_nxt = PH_DONE;
      endcase
    end
  end

  always_comb begin
    ctl_nxt              = ctl_r;
    accum_nxt            = accum_r;
    line_count_nxt       = line_count_r;
    trailer_nonempty_nxt = trailer_nonempty_r;
    chunk_nxt            = chunk_r;
    budget_nxt           = budget_r;
    status               = ST_CONSUMED;
    out_byte             = 8'd0;
    if (op == OP_START) begin
      budget_nxt           = budget_load;
      ctl_nxt              = SIZE_CTL_CLEAR;
      accum_nxt            = '0;
      line_count_nxt       = '0;
      trailer_nonempty_nxt = 1'b0;
      chunk_nxt            = '0;
      status               = ST_STARTED;
    end else begin
      unique case (phase_r)
        PH_SIZE: begin
          if (is_lf) begin
            ctl_nxt        = SIZE_CTL_CLEAR;
            accum_nxt      = '0;
            line_count_nxt = '0;
            if (size_bad)           status = ST_MALFORMED;
            else if (accum_r == '0) trailer_nonempty_nxt = 1'b0;
            else                    chunk_nxt = accum_r;
          end else if (in_byte != CH_CR && line_count_r < LCW'(SIZE_LINE_KEEP)) begin
            line_count_nxt = line_count_r + LCW'(1);
            ctl_nxt        = ctl_parsed;
            accum_nxt      = accum_parsed;
          end
        end
        PH_DATA: begin
          // bytes past the budget still count against the chunk
          if (budget_r != '0) begin
            budget_nxt = budget_r - LENGTH_BITS'(1);
            out_byte   = in_byte;
            status     = ST_BODY_BYTE;
          end
          chunk_nxt = chunk_dec;
        end
        PH_CRLF: begin
          if (is_lf) begin
            ctl_nxt        = SIZE_CTL_CLEAR;
            accum_nxt      = '0;
            line_count_nxt = '0;
          end
        end
        PH_TRAILER: begin
          if (is_lf) begin
            if (!trailer_nonempty_r) status = ST_COMPLETE;
            else                     trailer_nonempty_nxt = 1'b0;
          end else if (in_byte != CH_CR) begin
            trailer_nonempty_nxt = 1'b1;
          end
        end
        PH_DONE: status = ST_AFTER_END;
        default: status = ST_AFTER_END;
      endcase
    end
  end

  assign budget_wide    = CW'(budget_nxt);
  assign body_remaining = budget_wide[LEN_FIELD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r            <= PH_DONE;
      ctl_r              <= SIZE_CTL_CLEAR;
      accum_r            <= '0;
      line_count_r       <= '0;
      trailer_nonempty_r <= 1'b0;
      chunk_r            <= '0;
      budget_r           <= '0;
    end else if (item_fire) begin
      phase_r            <= phase_nxt;
      ctl_r              <= ctl_nxt;
      accum_r            <= accum_nxt;
      line_count_r       <= line_count_nxt;
      trailer_nonempty_r <= trailer_nonempty_nxt;
      chunk_r            <= chunk_nxt;
      budget_r           <= budget_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/http_chunked_body_decoder_unit.sv
// One input register, one decode step, one result register, which drives out_tvalid.
// Throughput: 1 item per cycle while out_tready does not stall the result register.
// The decoder state advances as an item moves from the input register to the result register.
// Reset (rst_n low, synchronous): both register stages empty, decoder idle at end of body,
//   length budget zero; bytes before the first start item report after-end.
`default_nettype none
module http_chunked_body_decoder_unit #(
  parameter int LENGTH_BITS    = 31,
  parameter int SIZE_LINE_KEEP = 39
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [hcbd_pkg::TDATA_W-1:0]    in_tdata,  // in_byte[7:0], entity_length[38:8]
  input  wire logic                            in_tuser,  // op
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [hcbd_pkg::TDATA_W-1:0]         out_tdata, // out_byte[7:0], body_remaining[38:8]
  output logic [hcbd_pkg::STATUS_W-1:0]        out_tuser  // status
);
  import hcbd_pkg::*;

  logic                   s1_valid_r, s1_valid_nxt;
  logic                   s1_op_r;
  logic [7:0]             s1_byte_r;
  logic [LEN_FIELD_W-1:0] s1_len_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_byte_r;
  status_t                out_status_r;
  logic [LEN_FIELD_W-1:0] out_remain_r;
  logic                   advance, s1_fire, in_fire;
  logic [7:0]             res_byte;
  status_t                res_status;
  logic [LEN_FIELD_W-1:0] res_remain;

  assign advance   = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  hcbd_core #(
    .LENGTH_BITS    (LENGTH_BITS),
    .SIZE_LINE_KEEP (SIZE_LINE_KEEP)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_fire      (s1_fire),
    .op             (s1_op_r),
    .in_byte        (s1_byte_r),
    .entity_length  (s1_len_r),
    .out_byte       (res_byte),
    .status         (res_status),
    .body_remaining (res_remain)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire)      s1_valid_nxt = 1'b1;
    else if (s1_fire) s1_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire)         out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= in_tuser;
      s1_byte_r <= in_tdata[7:0];
      s1_len_r  <= in_tdata[LEN_FIELD_W+7:8];
    end
    if (s1_fire) begin
      out_byte_r   <= res_byte;
      out_status_r <= res_status;
      out_remain_r <= res_remain;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_W - LEN_FIELD_W - 8){1'b0}}, out_remain_r, out_byte_r};
  assign out_tuser  = out_status_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid && !s1_valid_r)
    else $error("register stages not empty after reset");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_tvalid)
    else $error("decoded item did not reach the result register");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stalled while the input register is empty");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_byte_r) && $stable(s1_op_r))
    else $error("pending item lost while the result register is blocked");

endmodule
`default_nettype wire

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hcbd_pkg::*;

  localparam logic [30:0] LEN_MAX     = 31'h7FFF_FFFF;
  localparam int          LINE_KEEP   = 39;
  localparam int          ITEM_TARGET = 950;
  localparam int          HOLD_CYCLES = 64;

  typedef struct packed {
    logic        op;
    logic [7:0]  ch;
    logic [30:0] len;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    status_t     status;
    logic [30:0] remaining;
  } result_t;

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t res;
  } dir_row_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [TDATA_W-1:0]  in_tdata   = '0;  // in_byte[7:0], entity_length[38:8]
  logic                in_tuser   = 1'b0;  // op
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [TDATA_W-1:0]  out_tdata;  // out_byte[7:0], body_remaining[38:8]
  logic [STATUS_W-1:0] out_tuser;  // status

  // decoder state mirror
  phase_t      dec_phase   = PH_DONE;
  parse_step_t dec_step    = PS_BLANK;
  logic [30:0] dec_accum   = '0;
  logic [30:0] dec_chunk   = '0;
  logic [30:0] dec_budget  = '0;
  logic        dec_neg     = 1'b0;
  logic        dec_digit   = 1'b0;
  logic        dec_lone0   = 1'b0;
  logic        dec_trailer = 1'b0;
  int          dec_lines   = 0;

  result_t  pending_decodes[$];
  dir_row_t dir_tab[$];
  int       errors          = 0;
  int       sent            = 0;
  int       idle_pct        = 0;
  int       stall_pct       = 0;
  int       hold_cycles_req = 0;
  int       hold_left       = 0;

  always #4 clk = ~clk;

  http_chunked_body_decoder_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib, bit up);
    if (nib < 4'd10) return 8'("0") + 8'(nib);
    return (up ? 8'("A") : 8'("a")) + 8'(nib) - 8'd10;
  endfunction

  function automatic void restart_size_line();
    dec_accum = '0;
    dec_step  = PS_BLANK;
    dec_neg   = 1'b0;
    dec_digit = 1'b0;
    dec_lone0 = 1'b0;
    dec_lines = 0;
  endfunction

  // strtol-style base-16 scan, one character at a time
  function automatic void scan_size_char(logic [7:0] c);
    int d;
    d = hex_nibble(c);
    if (dec_step == PS_STOP) return;
    if (c == CH_SEMI || c == CH_NUL) begin
      dec_step = PS_STOP;
      return;
    end
    if (dec_step == PS_BLANK) begin
      if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) return;
      if (c == CH_PLUS) begin
        dec_step = PS_AFTER_SIGN;
        return;
      end
      if (c == CH_MINUS) begin
        dec_neg  = 1'b1;
        dec_step = PS_AFTER_SIGN;
        return;
      end
    end else if (dec_step == PS_DIGITS && dec_lone0 && (c == CH_X_LO || c == CH_X_UP)) begin
      dec_lone0 = 1'b0;
      dec_step  = PS_AFTER_SIGN;
      return;
    end
    if (d >= 0) begin
      dec_lone0 = !dec_digit && d == 0;
      dec_digit = 1'b1;
      // saturate once another nibble would not fit
      dec_accum = (dec_accum > (LEN_MAX >> 4)) ? LEN_MAX : {dec_accum[26:0], 4'(d)};
      dec_step  = PS_DIGITS;
    end else begin
      dec_step = PS_STOP;
    end
  endfunction

  function automatic result_t decode_item(item_t it);
    result_t     r;
    logic [30:0] sz;
    logic        bad;
    r.out_byte = '0;
    r.status   = ST_CONSUMED;
    if (it.op == OP_START) begin
      dec_budget  = it.len;
      dec_phase   = PH_SIZE;
      restart_size_line();
      dec_trailer = 1'b0;
      dec_chunk   = '0;
      r.status    = ST_STARTED;
    end else begin
      case (dec_phase)
        PH_SIZE: begin
          if (it.ch == CH_LF) begin
            bad = !dec_digit || (dec_neg && dec_accum != 0);
            sz  = dec_accum;
            restart_size_line();
            if (bad) begin
              dec_phase = PH_DONE;
              r.status  = ST_MALFORMED;
            end else if (sz == 0) begin
              dec_trailer = 1'b0;
              dec_phase   = PH_TRAILER;
            end else begin
              dec_chunk = sz;
              dec_phase = PH_DATA;
            end
          end else if (it.ch != CH_CR && dec_lines < LINE_KEEP) begin
            dec_lines++;
            scan_size_char(it.ch);
          end
        end
        PH_DATA: begin
          if (dec_budget != 0) begin
            dec_budget--;
            r.out_byte = it.ch;
            r.status   = ST_BODY_BYTE;
          end
          // dropped bytes still count against the chunk
          if (dec_chunk != 0) dec_chunk--;
          if (dec_chunk == 0) dec_phase = PH_CRLF;
        end
        PH_CRLF: begin
          if (it.ch == CH_LF) begin
            restart_size_line();
            dec_phase = PH_SIZE;
          end
        end
        PH_TRAILER: begin
          if (it.ch == CH_LF) begin
            if (!dec_trailer) begin
              dec_phase = PH_DONE;
              r.status  = ST_COMPLETE;
            end else begin
              dec_trailer = 1'b0;
            end
          end else if (it.ch != CH_CR) begin
            dec_trailer = 1'b1;
          end
        end
        default: r.status = ST_AFTER_END;
      endcase
    end
    r.remaining = dec_budget;
    return r;
  endfunction

  task automatic send_item(item_t it, bit typed, result_t typed_res);
    result_t r;
    int      gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= {1'b0, it.len, it.ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = decode_item(it);
    pending_decodes.push_back(typed ? typed_res : r);
    sent++;
  endtask

  task automatic send_byte(logic [7:0] c);
    item_t it;
    it.op  = OP_BYTE;
    it.ch  = c;
    it.len = 31'($urandom);
    send_item(it, 1'b0, '0);
  endtask

  task automatic send_start(logic [30:0] len);
    item_t it;
    it.op  = OP_START;
    it.ch  = 8'($urandom);
    it.len = len;
    send_item(it, 1'b0, '0);
  endtask

  task automatic send_size_line(logic [30:0] v, bit negative);
    int n;
    bit up;
    // overlong line: digits past the kept prefix are ignored
    if ($urandom_range(0, 19) == 0)
      repeat ($urandom_range(LINE_KEEP - 4, LINE_KEEP)) send_byte(CH_SPACE);
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0: send_byte(CH_SPACE);
        1: send_byte(CH_TAB);
        2: send_byte(CH_VT);
        default: send_byte(CH_FF);
      endcase
    end
    if (negative) send_byte(CH_MINUS);
    else if ($urandom_range(0, 5) == 0) send_byte(CH_PLUS);
    else if (v == 0 && $urandom_range(0, 3) == 0) send_byte(CH_MINUS);
    if ($urandom_range(0, 3) == 0) begin
      send_byte("0");
      send_byte($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
    end
    repeat ($urandom_range(0, 2)) send_byte("0");
    n = 1;
    while (n < 8 && (v >> (4 * n)) != 0) n++;
    up = 1'($urandom_range(0, 1));
    for (int i = n - 1; i >= 0; i--) send_byte(hex_char(4'(v >> (4 * i)), up));
    if ($urandom_range(0, 3) == 0) begin
      send_byte(CH_SEMI);
      repeat ($urandom_range(0, 8)) send_byte(8'($urandom_range(0, 9)) == 0 ? CH_NUL : "e");
    end
    if ($urandom_range(0, 3) != 0) send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  task automatic send_body();
    logic [30:0] len;
    logic [30:0] sz;
    int          nchunks;
    case ($urandom_range(0, 9))
      0: len = '0;
      1: len = LEN_MAX;
      2: len = 31'($urandom);
      default: len = 31'($urandom_range(0, 80));
    endcase
    send_start(len);
    nchunks = $urandom_range(0, 4);
    for (int k = 0; k < nchunks; k++) begin
      case ($urandom_range(0, 19))
        0: begin
          send_size_line(31'($urandom_range(1, 255)), 1'b1);
          repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
          return;
        end
        1: begin
          // saturating size; cut short by the next start
          repeat ($urandom_range(9, 11))
            send_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
          send_byte(CH_LF);
          repeat ($urandom_range(1, 20)) send_byte(8'($urandom));
          return;
        end
        2: begin
          // line without a digit
          if ($urandom_range(0, 1)) send_byte($urandom_range(0, 1) ? CH_SEMI : "g");
          send_byte(CH_LF);
          return;
        end
        default: ;
      endcase
      sz = ($urandom_range(0, 15) == 0) ? 31'($urandom_range(13, 48))
                                        : 31'($urandom_range(1, 12));
      send_size_line(sz, 1'b0);
      repeat (sz) send_byte(8'($urandom));
      if ($urandom_range(0, 11) == 0) return;
      if ($urandom_range(0, 7) == 0) send_byte("j");
      if ($urandom_range(0, 3) != 0) send_byte(CH_CR);
      send_byte(CH_LF);
    end
    send_size_line('0, 1'b0);
    repeat ($urandom_range(0, 2)) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(8'h21, 8'h7E)));
      if ($urandom_range(0, 1)) send_byte(CH_CR);
      send_byte(CH_LF);
    end
    if ($urandom_range(0, 3) != 0) send_byte(CH_CR);
    send_byte(CH_LF);
    repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
  endtask

  task automatic send_noise();
    item_t it;
    repeat ($urandom_range(4, 12)) begin
      it.op  = ($urandom_range(0, 9) == 0) ? OP_START : OP_BYTE;
      it.ch  = 8'($urandom);
      it.len = 31'($urandom);
      send_item(it, 1'b0, '0);
    end
  endtask

  function automatic void add_row(logic op, logic [7:0] ch, logic [30:0] len,
                                  bit typed = 1'b0, status_t st = ST_CONSUMED,
                                  logic [7:0] ob = '0, logic [30:0] rem = '0);
    dir_row_t row;
    row.it.op         = op;
    row.it.ch         = ch;
    row.it.len        = len;
    row.typed         = typed;
    row.res.out_byte  = ob;
    row.res.status    = st;
    row.res.remaining = rem;
    dir_tab.push_back(row);
  endfunction

  task automatic check_result();
    result_t want;
    if (pending_decodes.size() == 0) begin
      $error("unexpected result: out_tdata=%h out_tuser=%0d", out_tdata, out_tuser);
      errors++;
    end else begin
      want = pending_decodes.pop_front();
      if (out_tdata[7:0] !== want.out_byte) begin
        $error("out_byte: expected %0h, got %0h", want.out_byte, out_tdata[7:0]);
        errors++;
      end
      if (out_tuser !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, out_tuser);
        errors++;
      end
      if (out_tdata[38:8] !== want.remaining) begin
        $error("body_remaining: expected %0h, got %0h", want.remaining, out_tdata[38:8]);
        errors++;
      end
    end
  endtask

  // result side: check, then pick tready for the next cycle
  initial begin
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) check_result();
      if (hold_cycles_req != 0) begin
        hold_left       = hold_cycles_req;
        hold_cycles_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    bit held;
    bit drained;
    int mode;
    held    = 1'b0;
    drained = 1'b0;

    add_row(OP_BYTE,  "A",      '0,      1'b1, ST_AFTER_END, '0, '0);
    add_row(OP_START, 8'hFF,    LEN_MAX, 1'b1, ST_STARTED,   '0, LEN_MAX);
    add_row(OP_BYTE,  CH_SPACE, '0);
    add_row(OP_BYTE,  CH_MINUS, '0);
    add_row(OP_BYTE,  "0",      '0);
    add_row(OP_BYTE,  CH_LF,    '0,      1'b1, ST_CONSUMED,  '0, LEN_MAX);
    add_row(OP_BYTE,  "h",      '0);
    add_row(OP_BYTE,  CH_CR,    '0);
    add_row(OP_BYTE,  CH_LF,    LEN_MAX, 1'b1, ST_CONSUMED,  '0, LEN_MAX);
    add_row(OP_BYTE,  CH_CR,    '0);
    add_row(OP_BYTE,  CH_LF,    '0,      1'b1, ST_COMPLETE,  '0, LEN_MAX);
    add_row(OP_BYTE,  8'hFF,    '0,      1'b1, ST_AFTER_END, '0, LEN_MAX);
    add_row(OP_START, 8'h00,    '0,      1'b1, ST_STARTED,   '0, '0);
    add_row(OP_BYTE,  "0",      '0);
    add_row(OP_BYTE,  CH_X_UP,  '0);
    add_row(OP_BYTE,  "2",      '0);
    add_row(OP_BYTE,  CH_SEMI,  '0);
    add_row(OP_BYTE,  CH_NUL,   '0);
    add_row(OP_BYTE,  CH_LF,    '0);
    add_row(OP_BYTE,  8'hFF,    '0,      1'b1, ST_CONSUMED,  '0, '0);
    add_row(OP_BYTE,  8'h00,    '0,      1'b1, ST_CONSUMED,  '0, '0);
    add_row(OP_BYTE,  CH_LF,    '0);
    add_row(OP_BYTE,  CH_MINUS, '0);
    add_row(OP_BYTE,  "5",      '0);
    add_row(OP_BYTE,  CH_LF,    '0,      1'b1, ST_MALFORMED, '0, '0);
    add_row(OP_START, 8'h5A,    31'd3,   1'b1, ST_STARTED,   '0, 31'd3);
    add_row(OP_BYTE,  "1",      '0);
    add_row(OP_BYTE,  CH_LF,    '0);
    add_row(OP_BYTE,  8'hA5,    '0,      1'b1, ST_BODY_BYTE, 8'hA5, 31'd2);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);

    while (sent < ITEM_TARGET) begin
      mode = ((sent - dir_tab.size()) / 120) % 4;
      idle_pct  = (mode == 1) ? 69 : (mode == 3) ? 17 : 0;
      stall_pct = (mode == 2) ? 69 : (mode == 3) ? 17 : 0;
      if (!held && sent >= 350) begin
        // long receiver hold-off while input keeps coming
        held            = 1'b1;
        hold_cycles_req = HOLD_CYCLES;
      end
      if (!drained && sent >= 650) begin
        drained = 1'b1;
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_decodes.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 7) == 0) send_noise();
      else send_body();
    end

    in_tvalid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
